// ===== hdl/ipmb_frame_checker_defines.svh =====
// Assertion macros for the IPMB frame checker.
// Used by the top level; needs nothing else.
`ifndef IPMB_FRAME_CHECKER_DEFINES_SVH
`define IPMB_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IPMB_FC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPMB_FC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ipmb_fc_pkg.sv =====
// Shared types and constants for the IPMB frame checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipmb_fc_pkg;

    localparam logic [7:0] FLOOR_LENGTH    = 8'd5;
    localparam logic [7:0] HEADER_LAST_IDX = 8'd2;
    localparam logic [7:0] SEQ_LUN_IDX     = 8'd4;
    localparam logic [7:0] MIN_LEN_RESET   = 8'd7;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_SHORT_HEADER = 2'd1,
        ST_BODY_BAD     = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] byte_count;
        logic [7:0] header_sum;
        logic       header_good;
        logic [7:0] body_sum;
        logic [7:0] found_length;
        logic [7:0] seq_lun_byte;
    } t_frame_state;

endpackage

`default_nettype wire

// ===== hdl/ipmb_fc_accum.sv =====
// Per-byte update of the frame state: count, header and body sums, byte 4 capture, length search.
// Depends on ipmb_fc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipmb_fc_accum
    import ipmb_fc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 255
) (
    input  wire t_frame_state i_cur,
    input  wire logic [7:0]   i_byte,
    input  wire logic [7:0]   i_eff_min,
    output t_frame_state      o_next
);

    localparam logic [7:0] MaxBytes = 8'(MAX_FRAME_BYTES);

    logic [7:0] idx;
    logic [7:0] len;
    logic [7:0] hsum_add;
    logic [7:0] bsum_add;

    assign idx      = i_cur.byte_count;
    assign len      = idx + 8'd1;
    assign hsum_add = i_cur.header_sum + i_byte;
    assign bsum_add = i_cur.body_sum + i_byte;

    always_comb begin
        o_next = i_cur;
        if (idx < MaxBytes) begin
            if (idx <= HEADER_LAST_IDX) begin
                o_next.header_sum = hsum_add;
                if (idx == HEADER_LAST_IDX) begin
                    o_next.header_good = (hsum_add == 8'd0);
                end
            end else begin
                o_next.body_sum = bsum_add;
            end
            if (idx == SEQ_LUN_IDX) begin
                o_next.seq_lun_byte = i_byte;
            end
            o_next.byte_count = len;
            // latch the first prefix that passes both checks
            if ((i_cur.found_length == 8'd0) && (len >= i_eff_min)
                    && o_next.header_good && (o_next.body_sum == 8'd0)) begin
                o_next.found_length = len;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ipmb_frame_checker.sv =====
// IPMB frame checker: one received byte per item, one result per buffer.
// Throughput: one byte per cycle while the result channel does not stall; a last byte waits for a free result register.
// Result path: a taken last byte passes the input register, then the result register,
// which holds the verdict for its buffer.
// Reset (i_rst_n low, synchronous): frame state cleared, both stages empty,
// minimum frame length back to 7.
`timescale 1ns / 1ps
`default_nettype none
`include "ipmb_frame_checker_defines.svh"

module ipmb_frame_checker
    import ipmb_fc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 255
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // byte input channel
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_last_byte,
    // result channel
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_status,
    output logic [7:0]      o_first_valid_length,
    output logic [5:0]      o_request_sequence,
    output logic [1:0]      o_requester_lun,
    // configuration: minimum frame length
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    // Configuration register. Writes are to be made only while the block is idle;
    // the user must keep to this, as the block itself does not enforce it.
    logic [7:0] r_min_frame_length;
    logic [7:0] eff_min;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_frame_length <= MIN_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_min_frame_length <= i_cfg_data;
        end
    end

    // A frame needs its header and byte 4, so lift the minimum to five.
    assign eff_min = (r_min_frame_length < FLOOR_LENGTH) ? FLOOR_LENGTH
                                                         : r_min_frame_length;

    // Input register. A non-last byte always advances; a last byte advances
    // only when the result register is free or being emptied.
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;
    logic       out_free;
    logic       s1_fire;
    logic       s1_free;

    assign out_free = !o_valid || !i_stall;
    assign s1_fire  = r_s1_valid && (!r_s1_last || out_free);
    assign s1_free  = !r_s1_valid || s1_fire;
    assign o_stall  = !s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_valid) begin
            r_s1_byte <= i_rx_byte;
            r_s1_last <= i_last_byte;
        end
    end

    // Frame state: running count, header and body sums, found length.
    t_frame_state r_frame;
    t_frame_state n_frame;
    t_frame_state upd_frame;

    ipmb_fc_accum #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_accum (
        .i_cur     (r_frame),
        .i_byte    (r_s1_byte),
        .i_eff_min (eff_min),
        .o_next    (upd_frame)
    );

    // Clear the frame after its last byte so the next buffer starts afresh.
    always_comb begin
        n_frame = r_frame;
        if (s1_fire) begin
            n_frame = r_s1_last ? '0 : upd_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
        end else begin
            r_frame <= n_frame;
        end
    end

    // Verdict for the whole buffer, judged on the state after its last byte.
    t_status verdict;

    always_comb begin
        if ((upd_frame.byte_count < eff_min) || !upd_frame.header_good) begin
            verdict = ST_SHORT_HEADER;
        end else if (upd_frame.body_sum != 8'd0) begin
            verdict = ST_BODY_BAD;
        end else begin
            verdict = ST_OK;
        end
    end

    // Result register. Load on a last byte; drop once taken downstream.
    logic       r_out_valid;
    t_status    r_out_status;
    logic [7:0] r_out_found;
    logic [7:0] r_out_seq_lun;
    logic       load_out;

    assign load_out = s1_fire && r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status  <= verdict;
            r_out_found   <= upd_frame.found_length;
            r_out_seq_lun <= upd_frame.seq_lun_byte;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_status             = r_out_status;
    assign o_first_valid_length = r_out_found;
    assign o_request_sequence   = r_out_seq_lun[7:2];
    assign o_requester_lun      = r_out_seq_lun[1:0];

    // A buffer judged ok must have passed the length search somewhere.
    `IPMB_FC_ASSERT_NOW(a_ok_has_length, i_clk, i_rst_n,
        o_valid && (o_status == ST_OK), o_first_valid_length != 8'd0,
        "ok verdict without a found length")

    // The frame state is empty in the cycle after a last byte is consumed.
    `IPMB_FC_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n,
        s1_fire && r_s1_last, r_frame.byte_count == 8'd0,
        "frame state not cleared after last byte")

    // A found length never runs ahead of the byte count.
    `IPMB_FC_ASSERT_NOW(a_found_le_count, i_clk, i_rst_n,
        r_frame.found_length != 8'd0, r_frame.found_length <= r_frame.byte_count,
        "found length beyond byte count")

    // The count saturates at the frame limit.
    `IPMB_FC_ASSERT_NOW(a_count_sat, i_clk, i_rst_n,
        1'b1, r_frame.byte_count <= 8'(MAX_FRAME_BYTES),
        "byte count beyond frame limit")

endmodule

`default_nettype wire

// ===== tb/ipmb_frame_checker_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the IPMB frame checker: drives received bytes,
// predicts each buffer verdict and compares it with the result channel.
// Depends on ipmb_fc_pkg and the ipmb_frame_checker RTL.

module ipmb_frame_checker_test;
    import ipmb_fc_pkg::*;

    localparam int      MAX_BYTES        = 255;
    // Margin to allow after the last result before touching the register.
    localparam int      SETTLE_CYCLES    = 8;
    localparam int      DRAIN_LIMIT      = 20000;
    localparam int      REPORT_LIMIT     = 10;
    localparam int      BYTES_PER_PHASE  = 170;
    // Roughly 1000 items; even under heavy idling and stalling this is far
    // beyond the slowest correct run.
    localparam longint  TIMEOUT_NS       = 5_000_000;

    typedef logic [7:0] t_byte_q[$];

    typedef struct packed {
        t_status    status;
        logic [7:0] first_len;
        logic [5:0] seq;
        logic [1:0] lun;
    } t_verdict;

    // Scoreboard: tracks one buffer at a time and queues the verdicts it implies.
    class frame_verdict_model;
        logic [7:0] min_len;
        logic [7:0] byte_count;
        logic [7:0] header_sum;
        logic       header_good;
        logic [7:0] body_sum;
        logic [7:0] found_len;
        logic [7:0] seq_lun;
        t_verdict   pending[$];
        int         mismatches;

        function new();
            min_len    = MIN_LEN_RESET;
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_count  = '0;
            header_sum  = '0;
            header_good = 1'b0;
            body_sum    = '0;
            found_len   = '0;
            seq_lun     = '0;
        endfunction

        function int floor_min();
            return (min_len < FLOOR_LENGTH) ? int'(FLOOR_LENGTH) : int'(min_len);
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            int       idx;
            t_verdict v;
            idx = byte_count;
            // Past the cap bytes are dropped, but a last flag still closes the buffer.
            if (idx < MAX_BYTES) begin
                if (idx <= HEADER_LAST_IDX) begin
                    header_sum = header_sum + b;
                    if (idx == HEADER_LAST_IDX)
                        header_good = (header_sum == 8'd0);
                end else begin
                    body_sum = body_sum + b;
                end
                if (idx == SEQ_LUN_IDX)
                    seq_lun = b;
                byte_count = 8'(idx + 1);
                if (found_len == 8'd0 && (idx + 1) >= floor_min() && header_good
                        && body_sum == 8'd0)
                    found_len = 8'(idx + 1);
            end
            if (last) begin
                if (int'(byte_count) < floor_min() || !header_good)
                    v.status = ST_SHORT_HEADER;
                else if (body_sum != 8'd0)
                    v.status = ST_BODY_BAD;
                else
                    v.status = ST_OK;
                v.first_len = found_len;
                v.seq       = seq_lun[7:2];
                v.lun       = seq_lun[1:0];
                pending.push_back(v);
                clear_frame();
            end
        endfunction

        function void check_verdict(t_verdict got);
            t_verdict want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: status %0d len %0d seq %0d lun %0d",
                             got.status, got.first_len, got.seq, got.lun);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.first_len !== want.first_len ||
                    got.seq !== want.seq || got.lun !== want.lun) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"result mismatch: expected status %0d len %0d seq %0d lun %0d,",
                              " got status %0d len %0d seq %0d lun %0d"},
                             want.status, want.first_len, want.seq, want.lun,
                             got.status, got.first_len, got.seq, got.lun);
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic       o_stall;
    logic [7:0] i_rx_byte    = '0;
    logic       i_last_byte  = 1'b0;
    logic       o_valid;
    logic       i_stall      = 1'b0;
    logic [1:0] o_status;
    logic [7:0] o_first_valid_length;
    logic [5:0] o_request_sequence;
    logic [1:0] o_requester_lun;
    logic       i_cfg_valid  = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data   = '0;

    frame_verdict_model verdicts = new();

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int bytes_sent         = 0;

    ipmb_frame_checker #(
        .MAX_FRAME_BYTES (MAX_BYTES)
    ) dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_rx_byte            (i_rx_byte),
        .i_last_byte          (i_last_byte),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_status             (o_status),
        .o_first_valid_length (o_first_valid_length),
        .o_request_sequence   (o_request_sequence),
        .o_requester_lun      (o_requester_lun),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_data           (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: sample before this edge's updates land, then pick the
    // stall for the next cycle. One assignment to i_stall per edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            verdicts.check_verdict('{t_status'(o_status), o_first_valid_length,
                                     o_request_sequence, o_requester_lun});
        i_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Offer one byte, idling first at the sender's rate, and hold it until taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_rx_byte   <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_stall);
        verdicts.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_buffer(input t_byte_q frame_bytes);
        foreach (frame_bytes[k])
            send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
    endtask

    // Build a frame whose header and body checksums both close at len bytes.
    function automatic t_byte_q well_formed(int len);
        t_byte_q    fb;
        logic [7:0] sum;
        fb  = {};
        fb.push_back(8'($urandom_range(255)));
        fb.push_back(8'($urandom_range(255)));
        fb.push_back(8'd0 - fb[0] - fb[1]);
        sum = '0;
        for (int k = 3; k < len - 1; k++) begin
            fb.push_back(8'($urandom_range(255)));
            sum = sum + fb[k];
        end
        fb.push_back(8'd0 - sum);
        return fb;
    endfunction

    // Mostly valid frames with random content; the rest broken, cut short or noise.
    task automatic random_buffer();
        t_byte_q fb;
        int      pick;
        int      n;
        pick = $urandom_range(99);
        fb   = well_formed($urandom_range(5, 16));
        if (pick < 45) begin
        end else if (pick < 60) begin
            // Trailing zeros keep the body sum closed, so the first valid length
            // falls short of the buffer; sometimes spoil the end as well.
            n = $urandom_range(1, 3);
            repeat (n) fb.push_back(8'd0);
            if ($urandom_range(1))
                fb.push_back(8'($urandom_range(1, 255)));
        end else if (pick < 80) begin
            n = $urandom_range(fb.size() - 1);
            fb[n] = fb[n] ^ 8'($urandom_range(1, 255));
        end else if (pick < 90) begin
            n  = $urandom_range(1, 4);
            fb = fb[0:n-1];
        end else begin
            n  = $urandom_range(1, 16);
            fb = {};
            repeat (n) fb.push_back(8'($urandom_range(255)));
        end
        send_buffer(fb);
    endtask

    // Drop the input valid so the last byte is not taken again, then drain.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (verdicts.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_min_len(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        verdicts.min_len = value;
    endtask

    task automatic run_phase(input logic [7:0] min_len, input int idle_pct,
                             input int stall_pct);
        int start;
        wait_idle();
        write_min_len(min_len);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        start              = bytes_sent;
        while (bytes_sent - start < BYTES_PER_PHASE)
            random_buffer();
    endtask

    initial begin
        #TIMEOUT_NS;
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_byte_q fb;
        int      drain;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed buffers at the reset minimum of seven.
        // A lone byte: too short, byte 4 absent.
        send_buffer({8'hFF});
        // Minimal valid frame, all-ones sequence and LUN.
        send_buffer({8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h02, 8'h00});
        // Valid at seven, then a stray byte spoils the body sum.
        send_buffer({8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80});
        // Header sums to one: rejected despite a closed body.
        send_buffer({8'h80, 8'h80, 8'h01, 8'h00, 8'hA5, 8'h00, 8'h5B});

        // Lowest legal minimum, no idling.
        run_phase(8'd5, 0, 0);

        // Highest minimum, sender idling: only a full-length frame can pass.
        run_phase(8'd255, 72, 0);
        // Frame valid at the length cap, then bytes past the cap that must be ignored.
        fb = well_formed(MAX_BYTES);
        fb.push_back(8'($urandom_range(1, 255)));
        fb.push_back(8'($urandom_range(1, 255)));
        send_buffer(fb);

        // Minimum below the floor of five, receiver stalling.
        run_phase(8'd0, 0, 72);

        // Random minimum, both sides idling.
        run_phase(8'($urandom_range(6, 20)), 26, 26);

        i_valid <= 1'b0;
        drain = 0;
        while (verdicts.pending.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (verdicts.pending.size() != 0)
            verdicts.mismatches++;

        if (verdicts.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
